@@ rtl/bmc_pkg.sv @@
package bmc_pkg;

    localparam int DATA_CELLS_DEF    = 128;
    localparam int STACK_DEPTH_DEF   = 32;
    localparam int PROGRAM_BYTES_DEF = 1024;
    localparam int STEP_W            = 17;
    localparam logic [STEP_W-1:0] STEP_LIMIT = 17'd65536;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_RESUME = 2'd2;
    localparam logic [1:0] KIND_CONT   = 2'd3;

    localparam logic [2:0] EV_CHAR      = 3'd0;
    localparam logic [2:0] EV_NUM       = 3'd1;
    localparam logic [2:0] EV_NEED_CHAR = 3'd2;
    localparam logic [2:0] EV_NEED_NUM  = 3'd3;
    localparam logic [2:0] EV_HALT      = 3'd4;
    localparam logic [2:0] EV_ERROR     = 3'd5;

    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_READY     = 2'd1;
    localparam logic [1:0] MODE_WAIT_CHAR = 2'd2;
    localparam logic [1:0] MODE_WAIT_NUM  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam logic [1:0] PC_HOLD = 2'd0;
    localparam logic [1:0] PC_INC  = 2'd1;
    localparam logic [1:0] PC_LOOP = 2'd2;
    localparam logic [1:0] PC_SCAN = 2'd3;

    localparam logic [1:0] DP_HOLD = 2'd0;
    localparam logic [1:0] DP_INC  = 2'd1;
    localparam logic [1:0] DP_DEC  = 2'd2;

    localparam logic [2:0] CELL_NONE   = 3'd0;
    localparam logic [2:0] CELL_INC    = 3'd1;
    localparam logic [2:0] CELL_DEC    = 3'd2;
    localparam logic [2:0] CELL_SAVE   = 3'd3;
    localparam logic [2:0] CELL_SUPPLY = 3'd4;
    localparam logic [2:0] CELL_ZERO   = 3'd5;

    typedef struct packed {
        logic       init;
        logic       clear_step;
        logic       prog_wr;
        logic       rd_scan;
        logic [1:0] pc_op;
        logic [1:0] dp_op;
        logic [2:0] cell_op;
        logic       loop_push;
        logic       loop_pop;
        logic       save_push;
        logic       save_pop;
        logic       scan_init;
        logic       scan_next;
        logic       nest_inc;
        logic       nest_dec;
        logic       steps_clr;
        logic       steps_inc;
        logic       mode_wr;
        logic [1:0] mode_val;
        logic       res_set;
        logic [2:0] res_ev;
        logic       res_cell;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [7:0] prog_byte;
        logic       pc_oor;
        logic       scan_oor;
        logic       cell_zero;
        logic       loop_empty;
        logic       loop_full;
        logic       save_empty;
        logic       save_full;
        logic       nest_zero;
        logic       step_limit;
        logic       clear_done;
        logic [1:0] run_mode;
        logic       out_full;
    } status_t;

endpackage

@@ rtl/brainfuck_machine_core.sv @@
// Channel  Direction  Handshake         Payload
// s_*      in         s_tvalid/tready   tuser: kind; tdata: address, byte, value
// m_*      out        m_tvalid/tready   tuser: event; tdata: cell value
// A run item is accepted, then each instruction takes a program store read and then an
// execute step; when a bracket is skipped, each byte passed over is read and then
// checked; then any result moves to the output register. A start first clears the
// data cells.
// Reset returns the machine to idle with all pointers and depths at zero.
// A result waits in the output register; the next item is taken meanwhile, and a
// new result stalls until the output register has been taken.
module brainfuck_machine_core
    import bmc_pkg::*;
#(
    parameter int DATA_CELLS    = DATA_CELLS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int PROGRAM_BYTES = PROGRAM_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // load_address, program_byte, supplied_value, zero fill
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // out_value
    output logic [2:0]  m_tuser   // event_res
);

    cmd_t    cmd;
    status_t status;

    bmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmc_datapath #(
        .DATA_CELLS    (DATA_CELLS),
        .STACK_DEPTH   (STACK_DEPTH),
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .load_address   (s_tdata[9:0]),
        .program_byte   (s_tdata[17:10]),
        .supplied_value (s_tdata[49:18]),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_event      (m_tuser),
        .res_value      (m_tdata)
    );

endmodule

@@ rtl/bmc_ctrl.sv @@
module bmc_ctrl
    import bmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_kind,
    output logic       in_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLEAR    = 3'd1;
    localparam logic [2:0] ST_FETCH    = 3'd2;
    localparam logic [2:0] ST_EXEC     = 3'd3;
    localparam logic [2:0] ST_SCAN_RD  = 3'd4;
    localparam logic [2:0] ST_SCAN_CHK = 3'd5;
    localparam logic [2:0] ST_EMIT     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_LOAD:
                        begin
                            cmd.prog_wr = 1'b1;
                        end
                        KIND_START:
                        begin
                            cmd.init      = 1'b1;
                            cmd.steps_clr = 1'b1;
                            cmd.mode_wr   = 1'b1;
                            cmd.mode_val  = MODE_READY;
                            state_next    = ST_CLEAR;
                        end
                        KIND_RESUME:
                        begin
                            if (status.run_mode == MODE_WAIT_CHAR ||
                                status.run_mode == MODE_WAIT_NUM)
                            begin
                                cmd.cell_op   = CELL_SUPPLY;
                                cmd.pc_op     = PC_INC;
                                cmd.steps_clr = 1'b1;
                                cmd.mode_wr   = 1'b1;
                                cmd.mode_val  = MODE_READY;
                                state_next    = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            if (status.run_mode == MODE_READY)
                            begin
                                cmd.steps_clr = 1'b1;
                                state_next    = ST_FETCH;
                            end
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.cell_op    = CELL_ZERO;
                    cmd.clear_step = 1'b1;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.step_limit)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.pc_oor || status.prog_byte == CH_NUL)
                begin
                    cmd.mode_wr  = 1'b1;
                    cmd.mode_val = MODE_IDLE;
                    cmd.res_set  = 1'b1;
                    cmd.res_ev   = status.loop_empty ? EV_HALT : EV_ERROR;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.pc_op     = PC_INC;
                    cmd.steps_inc = 1'b1;
                    state_next    = ST_FETCH;
                    case (status.prog_byte)
                        CH_GT:    cmd.dp_op = DP_INC;
                        CH_LT:    cmd.dp_op = DP_DEC;
                        CH_PLUS:  cmd.cell_op = CELL_INC;
                        CH_MINUS: cmd.cell_op = CELL_DEC;
                        CH_DOT, CH_COLON:
                        begin
                            cmd.mode_wr  = 1'b1;
                            cmd.mode_val = MODE_READY;
                            cmd.res_set  = 1'b1;
                            cmd.res_ev   = (status.prog_byte == CH_DOT) ? EV_CHAR : EV_NUM;
                            cmd.res_cell = 1'b1;
                            state_next   = ST_EMIT;
                        end
                        CH_COMMA, CH_SEMI:
                        begin
                            cmd.pc_op    = PC_HOLD;
                            cmd.mode_wr  = 1'b1;
                            cmd.res_set  = 1'b1;
                            if (status.prog_byte == CH_COMMA)
                            begin
                                cmd.mode_val = MODE_WAIT_CHAR;
                                cmd.res_ev   = EV_NEED_CHAR;
                            end
                            else
                            begin
                                cmd.mode_val = MODE_WAIT_NUM;
                                cmd.res_ev   = EV_NEED_NUM;
                            end
                            state_next = ST_EMIT;
                        end
                        CH_OPEN:
                        begin
                            if (status.cell_zero)
                            begin
                                cmd.pc_op     = PC_HOLD;
                                cmd.steps_inc = 1'b0;
                                cmd.scan_init = 1'b1;
                                state_next    = ST_SCAN_RD;
                            end
                            else if (status.loop_full)
                            begin
                                cmd.pc_op    = PC_HOLD;
                                cmd.mode_wr  = 1'b1;
                                cmd.mode_val = MODE_IDLE;
                                cmd.res_set  = 1'b1;
                                cmd.res_ev   = EV_ERROR;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                cmd.loop_push = 1'b1;
                            end
                        end
                        CH_CLOSE:
                        begin
                            if (status.loop_empty)
                            begin
                                cmd.pc_op    = PC_HOLD;
                                cmd.mode_wr  = 1'b1;
                                cmd.mode_val = MODE_IDLE;
                                cmd.res_set  = 1'b1;
                                cmd.res_ev   = EV_ERROR;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                cmd.pc_op    = PC_LOOP;
                                cmd.loop_pop = 1'b1;
                            end
                        end
                        CH_HASH:
                        begin
                            cmd.save_push = !status.save_full;
                        end
                        CH_DOLLAR:
                        begin
                            if (!status.save_empty)
                            begin
                                cmd.save_pop = 1'b1;
                                cmd.cell_op  = CELL_SAVE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = ST_SCAN_RD;
                if (status.scan_oor || status.prog_byte == CH_NUL)
                begin
                    cmd.mode_wr  = 1'b1;
                    cmd.mode_val = MODE_IDLE;
                    cmd.res_set  = 1'b1;
                    cmd.res_ev   = EV_ERROR;
                    state_next   = ST_EMIT;
                end
                else if (status.prog_byte == CH_OPEN)
                begin
                    cmd.nest_inc  = 1'b1;
                    cmd.scan_next = 1'b1;
                end
                else if (status.prog_byte == CH_CLOSE)
                begin
                    if (status.nest_zero)
                    begin
                        cmd.pc_op     = PC_SCAN;
                        cmd.steps_inc = 1'b1;
                        state_next    = ST_FETCH;
                    end
                    else
                    begin
                        cmd.nest_dec  = 1'b1;
                        cmd.scan_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bmc_datapath.sv @@
module bmc_datapath
    import bmc_pkg::*;
#(
    parameter int DATA_CELLS    = DATA_CELLS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int PROGRAM_BYTES = PROGRAM_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [9:0]  load_address,
    input  logic [7:0]  program_byte,
    input  logic [31:0] supplied_value,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  res_event,
    output logic [31:0] res_value
);

    localparam int DW = $clog2(DATA_CELLS);
    localparam int PA = $clog2(PROGRAM_BYTES);
    localparam int SA = $clog2(STACK_DEPTH);

    logic [7:0]  prog_mem [PROGRAM_BYTES];
    logic [31:0] cell_mem [DATA_CELLS];
    logic [PA-1:0] loop_mem [STACK_DEPTH];
    logic [31:0] save_mem [STACK_DEPTH];

    logic [PA:0]   pc_reg, pc_next;
    logic [DW-1:0] dp_reg, dp_next;
    logic [SA:0]   loop_depth_reg, loop_depth_next;
    logic [SA:0]   save_depth_reg, save_depth_next;
    logic [1:0]    mode_reg, mode_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [PA:0]   scan_reg, scan_next;
    logic [PA:0]   nest_reg, nest_next;
    logic [DW:0]   clear_reg, clear_next;
    logic          valid_reg, valid_next;
    logic [2:0]    pend_ev_reg;
    logic [31:0]   pend_val_reg;
    logic [2:0]    ev_reg;
    logic [31:0]   val_reg;

    logic [7:0]    prog_rdata;
    logic [31:0]   cell_rdata;
    logic [PA-1:0] loop_rdata;
    logic [31:0]   save_rdata;

    logic [PA:0]   prog_raddr;
    logic [SA-1:0] loop_top, save_top;
    logic [DW-1:0] cell_waddr;
    logic [31:0]   cell_wdata;
    logic          cell_we;
    logic [PA:0]   load_ext;

    assign prog_raddr = cmd.rd_scan ? scan_reg : pc_reg;
    assign loop_top   = SA'(loop_depth_reg - 1'b1);
    assign save_top   = SA'(save_depth_reg - 1'b1);
    assign load_ext   = (PA+1)'(load_address);

    always_ff @(posedge clk)
    begin
        if (cmd.prog_wr && 32'(load_address) < PROGRAM_BYTES)
        begin
            prog_mem[load_ext[PA-1:0]] <= program_byte;
        end
        prog_rdata <= prog_mem[prog_raddr[PA-1:0]];
    end

    always_comb
    begin
        cell_we    = 1'b1;
        cell_waddr = dp_reg;
        case (cmd.cell_op)
            CELL_INC:    cell_wdata = cell_rdata + 32'd1;
            CELL_DEC:    cell_wdata = cell_rdata - 32'd1;
            CELL_SAVE:   cell_wdata = save_rdata;
            CELL_SUPPLY: cell_wdata = supplied_value;
            CELL_ZERO:
            begin
                cell_wdata = '0;
                cell_waddr = clear_reg[DW-1:0];
            end
            default:
            begin
                cell_wdata = '0;
                cell_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rdata <= cell_mem[dp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.loop_push)
        begin
            loop_mem[loop_depth_reg[SA-1:0]] <= pc_reg[PA-1:0];
        end
        loop_rdata <= loop_mem[loop_top];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save_push)
        begin
            save_mem[save_depth_reg[SA-1:0]] <= cell_rdata;
        end
        save_rdata <= save_mem[save_top];
    end

    always_comb
    begin
        pc_next         = pc_reg;
        dp_next         = dp_reg;
        loop_depth_next = loop_depth_reg;
        save_depth_next = save_depth_reg;
        mode_next       = mode_reg;
        steps_next      = steps_reg;
        scan_next       = scan_reg;
        nest_next       = nest_reg;
        clear_next      = clear_reg;
        valid_next      = valid_reg;

        case (cmd.pc_op)
            PC_INC:  pc_next = pc_reg + 1'b1;
            PC_LOOP: pc_next = {1'b0, loop_rdata};
            PC_SCAN: pc_next = scan_reg + 1'b1;
            default: pc_next = pc_reg;
        endcase

        case (cmd.dp_op)
            DP_INC:  dp_next = (32'(dp_reg) == DATA_CELLS - 1) ? '0 : dp_reg + 1'b1;
            DP_DEC:  dp_next = (dp_reg == '0) ? DW'(DATA_CELLS - 1) : dp_reg - 1'b1;
            default: dp_next = dp_reg;
        endcase

        if (cmd.loop_push)
        begin
            loop_depth_next = loop_depth_reg + 1'b1;
        end
        else if (cmd.loop_pop)
        begin
            loop_depth_next = loop_depth_reg - 1'b1;
        end
        if (cmd.save_push)
        begin
            save_depth_next = save_depth_reg + 1'b1;
        end
        else if (cmd.save_pop)
        begin
            save_depth_next = save_depth_reg - 1'b1;
        end

        if (cmd.mode_wr)
        begin
            mode_next = cmd.mode_val;
        end
        if (cmd.steps_clr)
        begin
            steps_next = '0;
        end
        else if (cmd.steps_inc)
        begin
            steps_next = steps_reg + 1'b1;
        end

        if (cmd.scan_init)
        begin
            scan_next = pc_reg + 1'b1;
            nest_next = '0;
        end
        else
        begin
            if (cmd.scan_next)
            begin
                scan_next = scan_reg + 1'b1;
            end
            if (cmd.nest_inc)
            begin
                nest_next = nest_reg + 1'b1;
            end
            else if (cmd.nest_dec)
            begin
                nest_next = nest_reg - 1'b1;
            end
        end

        if (cmd.init)
        begin
            pc_next         = '0;
            dp_next         = '0;
            loop_depth_next = '0;
            save_depth_next = '0;
            clear_next      = '0;
        end
        else if (cmd.clear_step)
        begin
            clear_next = clear_reg + 1'b1;
        end

        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            dp_reg         <= '0;
            loop_depth_reg <= '0;
            save_depth_reg <= '0;
            mode_reg       <= MODE_IDLE;
            steps_reg      <= '0;
            scan_reg       <= '0;
            nest_reg       <= '0;
            clear_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            dp_reg         <= dp_next;
            loop_depth_reg <= loop_depth_next;
            save_depth_reg <= save_depth_next;
            mode_reg       <= mode_next;
            steps_reg      <= steps_next;
            scan_reg       <= scan_next;
            nest_reg       <= nest_next;
            clear_reg      <= clear_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            pend_ev_reg  <= cmd.res_ev;
            pend_val_reg <= cmd.res_cell ? cell_rdata : '0;
        end
        if (cmd.out_load)
        begin
            ev_reg  <= pend_ev_reg;
            val_reg <= pend_val_reg;
        end
    end

    assign res_valid = valid_reg;
    assign res_event = ev_reg;
    assign res_value = val_reg;

    assign status.prog_byte  = prog_rdata;
    assign status.pc_oor     = 32'(pc_reg) >= PROGRAM_BYTES;
    assign status.scan_oor   = 32'(scan_reg) >= PROGRAM_BYTES;
    assign status.cell_zero  = (cell_rdata == '0);
    assign status.loop_empty = (loop_depth_reg == '0);
    assign status.loop_full  = (32'(loop_depth_reg) >= STACK_DEPTH);
    assign status.save_empty = (save_depth_reg == '0);
    assign status.save_full  = (32'(save_depth_reg) >= STACK_DEPTH);
    assign status.nest_zero  = (nest_reg == '0);
    assign status.step_limit = (steps_reg == STEP_LIMIT);
    assign status.clear_done = (32'(clear_reg) == DATA_CELLS);
    assign status.run_mode   = mode_reg;
    assign status.out_full   = valid_reg && !res_ready;

endmodule
